// ===== rtl/ptp_pkg.sv =====
// package for the pulse to pcm box resampler: state type and field widths
`default_nettype none
package ptp_pkg;

    localparam int unsigned SR_W    = 20;
    localparam int unsigned TR_W    = 32;
    localparam int unsigned DUR_W   = 32;
    localparam int unsigned ACC_W   = 52;
    localparam int unsigned SMP_W   = 8;
    localparam int unsigned PROD_W  = 40;
    localparam int unsigned CNT_W   = 6;
    localparam int unsigned IN_W    = 40;
    localparam int unsigned OUT_W   = 64;

    localparam logic [SR_W-1:0]  SR_RESET = 20'd44100;
    localparam logic [TR_W-1:0]  TR_RESET = 32'd3500000;
    localparam logic [SMP_W-1:0] SMP_MAX  = 8'd255;

    localparam logic [CNT_W-1:0] MUL_STEPS = 6'd20;
    localparam logic [CNT_W-1:0] SMP_STEPS = 6'd40;
    localparam logic [CNT_W-1:0] RUN_STEPS = 6'd52;

    localparam logic CFG_SAMPLE_RATE = 1'b0;
    localparam logic CFG_TICK_RATE   = 1'b1;

    localparam logic REQ_PULSE = 1'b0;
    localparam logic REQ_FLUSH = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL,
        S_CMP,
        S_LDS,
        S_DIVS,
        S_SMP,
        S_DIVR,
        S_UPD,
        S_OUT_SMP,
        S_OUT_RUN
    } t_state;

endpackage
`default_nettype wire

// ===== rtl/pulse_to_pcm_box_resampler.sv =====
// pulse to 8-bit pcm box resampler, bit-serial multiply and restoring divide
// a pulse runs the bit-serial multiply, then a compare, then the sample division when it
// closes a sample, then the run division, before its first result; a flush runs the sample division
// one request at a time, taken only in idle once its results are out; the multiplier works
// one bit per cycle and one restoring divider is shared by the sample and run divisions
// reset: synchronous active low, rates to 44100 and 3500000, accumulators cleared
`default_nettype none
module pulse_to_pcm_box_resampler (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_we,
    input  wire logic                        i_cfg_idx,
    input  wire logic [ptp_pkg::TR_W-1:0]    i_cfg_data,
    input  wire logic                        i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    input  wire logic [ptp_pkg::IN_W-1:0]    i_s_axis_tdata,   // duration[31:0], level[32]
    input  wire logic                        i_s_axis_tuser,   // req_type
    output logic                             o_m_axis_tvalid,
    input  wire logic                        i_m_axis_tready,
    output logic [ptp_pkg::OUT_W-1:0]        o_m_axis_tdata,   // sample[7:0], repeat_count[59:8]
    output logic                             o_m_axis_tlast    // last
);

    ptp_pkg::t_state r_state, n_state;

    logic [ptp_pkg::SR_W-1:0]   r_sr;
    logic [ptp_pkg::TR_W-1:0]   r_tr;
    logic [31:0]                r_hacc;
    logic [31:0]                r_elap;
    logic [ptp_pkg::DUR_W-1:0]  r_dur;
    logic                       r_lvl;
    logic [ptp_pkg::SR_W-1:0]   r_mr;
    logic [ptp_pkg::ACC_W-1:0]  r_acc;
    logic [31:0]                r_rem;
    logic [ptp_pkg::ACC_W-1:0]  r_quo;
    logic [ptp_pkg::CNT_W-1:0]  r_cnt;
    logic [ptp_pkg::SMP_W-1:0]  r_smp;
    logic [ptp_pkg::ACC_W-1:0]  r_runs;
    logic                       r_has_smp;
    logic                       r_flush;

    logic [31:0]                t_eff;
    logic [31:0]                left;
    logic                       boundary;
    logic [32:0]                div_sh;
    logic                       div_ge;
    logic [32:0]                div_diff;
    logic [ptp_pkg::PROD_W-1:0] prod;
    logic                       in_acc;
    logic                       out_acc;
    logic                       cnt_end;
    logic                       smp_last;

    assign t_eff    = (r_tr == '0) ? 32'd1 : r_tr;
    assign left     = t_eff - r_elap;
    assign boundary = r_acc >= {20'd0, left};
    assign div_sh   = {r_rem, r_quo[ptp_pkg::ACC_W-1]};
    assign div_ge   = div_sh >= {1'b0, t_eff};
    assign div_diff = div_sh - {1'b0, t_eff};
    assign prod     = {r_hacc, 8'd0} - {8'd0, r_hacc};
    assign in_acc   = i_s_axis_tvalid && o_s_axis_tready;
    assign out_acc  = o_m_axis_tvalid && i_m_axis_tready;
    assign cnt_end  = r_cnt == 6'd1;
    assign smp_last = r_flush || (r_runs == '0);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ptp_pkg::S_IDLE: begin
                if (in_acc) begin
                    if (i_s_axis_tuser == ptp_pkg::REQ_FLUSH) begin
                        if (r_elap != '0) n_state = ptp_pkg::S_LDS;
                    end else begin
                        n_state = ptp_pkg::S_MUL;
                    end
                end
            end
            ptp_pkg::S_MUL:  if (cnt_end) n_state = ptp_pkg::S_CMP;
            ptp_pkg::S_CMP:  n_state = boundary ? ptp_pkg::S_LDS : ptp_pkg::S_DIVR;
            ptp_pkg::S_LDS:  n_state = ptp_pkg::S_DIVS;
            ptp_pkg::S_DIVS: if (cnt_end) n_state = ptp_pkg::S_SMP;
            ptp_pkg::S_SMP:  n_state = r_flush ? ptp_pkg::S_OUT_SMP : ptp_pkg::S_DIVR;
            ptp_pkg::S_DIVR: if (cnt_end) n_state = ptp_pkg::S_UPD;
            ptp_pkg::S_UPD: begin
                if (r_has_smp)       n_state = ptp_pkg::S_OUT_SMP;
                else if (r_quo != '0) n_state = ptp_pkg::S_OUT_RUN;
                else                 n_state = ptp_pkg::S_IDLE;
            end
            ptp_pkg::S_OUT_SMP: begin
                if (out_acc) n_state = smp_last ? ptp_pkg::S_IDLE : ptp_pkg::S_OUT_RUN;
            end
            ptp_pkg::S_OUT_RUN: if (out_acc) n_state = ptp_pkg::S_IDLE;
            default: n_state = ptp_pkg::S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_s_axis_tready = 1'b0;
        o_m_axis_tvalid = 1'b0;
        o_m_axis_tdata  = {4'd0, r_runs, r_smp};
        o_m_axis_tlast  = 1'b1;
        case (r_state)
            ptp_pkg::S_IDLE: o_s_axis_tready = 1'b1;
            ptp_pkg::S_OUT_SMP: begin
                o_m_axis_tvalid = 1'b1;
                o_m_axis_tdata  = {4'd0, 52'd1, r_smp};
                o_m_axis_tlast  = smp_last;
            end
            ptp_pkg::S_OUT_RUN: begin
                o_m_axis_tvalid = 1'b1;
                o_m_axis_tdata  = {4'd0, r_runs, (r_lvl ? ptp_pkg::SMP_MAX : 8'd0)};
                o_m_axis_tlast  = 1'b1;
            end
            default: o_s_axis_tready = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ptp_pkg::S_IDLE;
            r_sr      <= ptp_pkg::SR_RESET;
            r_tr      <= ptp_pkg::TR_RESET;
            r_hacc    <= '0;
            r_elap    <= '0;
            r_cnt     <= '0;
            r_has_smp <= 1'b0;
            r_flush   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                if (i_cfg_idx == ptp_pkg::CFG_SAMPLE_RATE) r_sr <= i_cfg_data[ptp_pkg::SR_W-1:0];
                else                                       r_tr <= i_cfg_data;
            end
            case (r_state)
                ptp_pkg::S_IDLE: begin
                    if (in_acc) begin
                        r_flush   <= i_s_axis_tuser == ptp_pkg::REQ_FLUSH;
                        r_has_smp <= i_s_axis_tuser == ptp_pkg::REQ_FLUSH;
                        r_cnt     <= ptp_pkg::MUL_STEPS;
                    end
                end
                ptp_pkg::S_MUL: r_cnt <= r_cnt - 6'd1;
                ptp_pkg::S_CMP: begin
                    r_has_smp <= boundary;
                    if (boundary) begin
                        r_hacc <= r_hacc + (r_lvl ? left : 32'd0);
                        r_elap <= '0;
                    end else begin
                        r_cnt <= ptp_pkg::RUN_STEPS;
                    end
                end
                ptp_pkg::S_LDS: begin
                    r_hacc <= '0;
                    r_elap <= '0;
                    r_cnt  <= ptp_pkg::SMP_STEPS;
                end
                ptp_pkg::S_DIVS: r_cnt <= r_cnt - 6'd1;
                ptp_pkg::S_SMP:  r_cnt <= ptp_pkg::RUN_STEPS;
                ptp_pkg::S_DIVR: r_cnt <= r_cnt - 6'd1;
                ptp_pkg::S_UPD: begin
                    r_elap <= r_elap + r_rem;
                    if (r_lvl) r_hacc <= r_hacc + r_rem;
                end
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            ptp_pkg::S_IDLE: begin
                r_dur  <= i_s_axis_tdata[ptp_pkg::DUR_W-1:0];
                r_lvl  <= i_s_axis_tdata[ptp_pkg::DUR_W];
                r_mr   <= r_sr;
                r_acc  <= '0;
                r_runs <= '0;
            end
            ptp_pkg::S_MUL: begin
                r_acc <= {r_acc[ptp_pkg::ACC_W-2:0], 1'b0}
                         + (r_mr[ptp_pkg::SR_W-1] ? {20'd0, r_dur} : '0);
                r_mr  <= {r_mr[ptp_pkg::SR_W-2:0], 1'b0};
            end
            ptp_pkg::S_CMP: begin
                if (boundary) begin
                    r_acc <= r_acc - {20'd0, left};
                end else begin
                    r_rem <= '0;
                    r_quo <= r_acc;
                end
            end
            ptp_pkg::S_LDS: begin
                r_rem <= '0;
                r_quo <= {prod, 12'd0};
            end
            ptp_pkg::S_DIVS, ptp_pkg::S_DIVR: begin
                r_rem <= div_ge ? div_diff[31:0] : div_sh[31:0];
                r_quo <= {r_quo[ptp_pkg::ACC_W-2:0], div_ge};
            end
            ptp_pkg::S_SMP: begin
                r_smp <= (r_quo[ptp_pkg::ACC_W-1:8] != '0) ? ptp_pkg::SMP_MAX : r_quo[7:0];
                r_rem <= '0;
                r_quo <= r_acc;
            end
            ptp_pkg::S_UPD: r_runs <= r_quo;
            default: r_mr <= r_mr;
        endcase
    end

endmodule
`default_nettype wire

// ===== verif/tb_top.sv =====
// self-checking testbench for pulse_to_pcm_box_resampler: directed table, random phases
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import ptp_pkg::*;

    localparam int DIR_N      = 33;
    localparam int PHASES     = 9;
    localparam int PHASE_REQS = 95;
    localparam int SETTLE_CYC = 200;
    localparam int HOLD_AT    = 120;
    localparam int HOLD_CYC   = 600;
    localparam int UNTYPED    = -1;

    typedef struct packed {
        logic [SMP_W-1:0] smp;
        logic [ACC_W-1:0] reps;
        logic             last;
    } t_pcm;

    typedef enum logic {ROW_CFG, ROW_REQ} t_row_kind;

    typedef struct {
        t_row_kind        kind;
        logic             idx;
        logic [TR_W-1:0]  value;
        logic             rtype;
        logic [DUR_W-1:0] dur;
        logic             lvl;
        int               n_typed;
        t_pcm             r0;
        t_pcm             r1;
    } t_stim_row;

    localparam t_pcm NO_RES = '0;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_we = 1'b0;
    logic               i_cfg_idx = CFG_SAMPLE_RATE;
    logic [TR_W-1:0]    i_cfg_data = '0;
    logic               i_s_axis_tvalid = 1'b0;
    logic               o_s_axis_tready;
    logic [IN_W-1:0]    i_s_axis_tdata = '0;   // duration[31:0], level[32]
    logic               i_s_axis_tuser = REQ_PULSE;   // req_type
    logic               o_m_axis_tvalid;
    logic               i_m_axis_tready = 1'b0;
    logic [OUT_W-1:0]   o_m_axis_tdata;   // sample[7:0], repeat_count[59:8]
    logic               o_m_axis_tlast;

    pulse_to_pcm_box_resampler u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    always #4 i_clk = ~i_clk;

    // predictor copy of the registers and accumulators
    logic [SR_W-1:0] sr_cfg      = SR_RESET;
    logic [TR_W-1:0] tick_cfg    = TR_RESET;
    logic [31:0]     high_acc    = '0;
    logic [31:0]     elapsed_acc = '0;

    t_pcm pred_res [2];
    int   pred_n;
    t_pcm pcm_expected_q [$];
    int   mismatches = 0;

    // hand-computed results that go with the request on the bus
    int   req_typed_n = UNTYPED;
    t_pcm req_typed [2];

    int tx_calm = 0;
    int rx_calm = 0;

    t_stim_row dir_tab [DIR_N] = '{
        '{ROW_REQ, CFG_SAMPLE_RATE, 32'd0, REQ_FLUSH, 32'd0, 1'b0, 0, NO_RES, NO_RES},
        '{ROW_REQ, CFG_SAMPLE_RATE, 32'd0, REQ_PULSE, 32'd0, 1'b0, 0, NO_RES, NO_RES},
        '{ROW_REQ, CFG_SAMPLE_RATE, 32'd0, REQ_PULSE, 32'd80, 1'b1, 1,
          '{8'd255, 52'd1, 1'b1}, NO_RES},
        '{ROW_REQ, CFG_SAMPLE_RATE, 32'd0, REQ_FLUSH, 32'd0, 1'b0, 1,
          '{8'd2, 52'd1, 1'b1}, NO_RES},
        '{ROW_CFG, CFG_SAMPLE_RATE, 32'd1, REQ_PULSE, 32'd0, 1'b0, 0, NO_RES, NO_RES},
        '{ROW_CFG, CFG_TICK_RATE, 32'd4, REQ_PULSE, 32'd0, 1'b0, 0, NO_RES, NO_RES},
        '{ROW_REQ, CFG_SAMPLE_RATE, 32'd0, REQ_PULSE, 32'd2, 1'b1, 0, NO_RES, NO_RES},
        '{ROW_REQ, CFG_SAMPLE_RATE, 32'd0, REQ_FLUSH, 32'd0, 1'b0, 1,
          '{8'd127, 52'd1, 1'b1}, NO_RES},
        '{ROW_REQ, CFG_SAMPLE_RATE, 32'd0, REQ_PULSE, 32'd9, 1'b0, 2,
          '{8'd0, 52'd1, 1'b0}, '{8'd0, 52'd1, 1'b1}},
        '{ROW_REQ, CFG_SAMPLE_RATE, 32'd0, REQ_PULSE, 32'd11, 1'b1, 2,
          '{8'd191, 52'd1, 1'b0}, '{8'd255, 52'd2, 1'b1}},
        '{ROW_REQ, CFG_SAMPLE_RATE, 32'd0, REQ_PULSE, 32'd3, 1'b1, 0, NO_RES, NO_RES},
        // tick rate lowered onto the elapsed time: no time left in the sample
        '{ROW_CFG, CFG_TICK_RATE, 32'd3, REQ_PULSE, 32'd0, 1'b0, 0, NO_RES, NO_RES},
        '{ROW_REQ, CFG_SAMPLE_RATE, 32'd0, REQ_PULSE, 32'd0, 1'b0, 1,
          '{8'd255, 52'd1, 1'b1}, NO_RES},
        '{ROW_REQ, CFG_SAMPLE_RATE, 32'd0, REQ_PULSE, 32'd2, 1'b1, 0, NO_RES, NO_RES},
        // tick rate below the elapsed time: wrapped time left, saturated sample
        '{ROW_CFG, CFG_TICK_RATE, 32'd1, REQ_PULSE, 32'd0, 1'b0, 0, NO_RES, NO_RES},
        '{ROW_REQ, CFG_SAMPLE_RATE, 32'd0, REQ_PULSE, 32'd1, 1'b0, 1,
          '{8'd0, 52'd1, 1'b1}, NO_RES},
        '{ROW_REQ, CFG_SAMPLE_RATE, 32'd0, REQ_FLUSH, 32'd0, 1'b0, 1,
          '{8'd255, 52'd1, 1'b1}, NO_RES},
        '{ROW_CFG, CFG_SAMPLE_RATE, 32'd0, REQ_PULSE, 32'd0, 1'b0, 0, NO_RES, NO_RES},
        '{ROW_REQ, CFG_SAMPLE_RATE, 32'd0, REQ_PULSE, 32'hFFFF_FFFF, 1'b1, 0, NO_RES, NO_RES},
        '{ROW_CFG, CFG_SAMPLE_RATE, 32'hF_FFFF, REQ_PULSE, 32'd0, 1'b0, 0, NO_RES, NO_RES},
        '{ROW_CFG, CFG_TICK_RATE, 32'd0, REQ_PULSE, 32'd0, 1'b0, 0, NO_RES, NO_RES},
        '{ROW_REQ, CFG_SAMPLE_RATE, 32'd0, REQ_PULSE, 32'hFFFF_FFFF, 1'b1, 2,
          '{8'd255, 52'd1, 1'b0}, '{8'd255, 52'hF_FFFE_FFF0_0000, 1'b1}},
        '{ROW_REQ, CFG_SAMPLE_RATE, 32'd0, REQ_PULSE, 32'd0, 1'b0, 0, NO_RES, NO_RES},
        '{ROW_CFG, CFG_TICK_RATE, 32'hFFFF_FFFF, REQ_PULSE, 32'd0, 1'b0, 0, NO_RES, NO_RES},
        '{ROW_CFG, CFG_SAMPLE_RATE, 32'd1, REQ_PULSE, 32'd0, 1'b0, 0, NO_RES, NO_RES},
        '{ROW_REQ, CFG_SAMPLE_RATE, 32'd0, REQ_PULSE, 32'hFFFF_FFFF, 1'b1, 1,
          '{8'd255, 52'd1, 1'b1}, NO_RES},
        '{ROW_REQ, CFG_SAMPLE_RATE, 32'd0, REQ_PULSE, 32'h8000_0000, 1'b1, 0, NO_RES, NO_RES},
        '{ROW_REQ, CFG_SAMPLE_RATE, 32'd0, REQ_PULSE, 32'h7FFF_FFFF, 1'b0, 1,
          '{8'd127, 52'd1, 1'b1}, NO_RES},
        '{ROW_CFG, CFG_SAMPLE_RATE, 32'd44100, REQ_PULSE, 32'd0, 1'b0, 0, NO_RES, NO_RES},
        '{ROW_CFG, CFG_TICK_RATE, 32'd3500000, REQ_PULSE, 32'd0, 1'b0, 0, NO_RES, NO_RES},
        '{ROW_REQ, CFG_SAMPLE_RATE, 32'd0, REQ_PULSE, 32'd12345, 1'b1, UNTYPED,
          NO_RES, NO_RES},
        '{ROW_REQ, CFG_SAMPLE_RATE, 32'd0, REQ_PULSE, 32'd200, 1'b0, UNTYPED,
          NO_RES, NO_RES},
        '{ROW_REQ, CFG_SAMPLE_RATE, 32'd0, REQ_FLUSH, 32'd0, 1'b0, UNTYPED,
          NO_RES, NO_RES}
    };

    function automatic logic [SMP_W-1:0] box_level(logic [31:0] tick);
        logic [63:0] v;
        v = ({56'b0, SMP_MAX} * {32'b0, high_acc}) / {32'b0, tick};
        return (v > {56'b0, SMP_MAX}) ? SMP_MAX : v[SMP_W-1:0];
    endfunction

    task automatic predict_pcm(input logic rtype, input logic [DUR_W-1:0] dur,
                               input logic lvl);
        logic [31:0] tick;
        logic [31:0] left;
        logic [63:0] passed;
        logic [63:0] runs;
        tick = (tick_cfg == '0) ? 32'd1 : tick_cfg;
        pred_n = 0;
        if (rtype == REQ_FLUSH) begin
            if (elapsed_acc != '0) begin
                pred_res[0] = '{box_level(tick), 52'd1, 1'b1};
                pred_n = 1;
                high_acc = '0;
                elapsed_acc = '0;
            end
        end else begin
            passed = {32'b0, dur} * {44'b0, sr_cfg};
            left = tick - elapsed_acc;
            if (passed >= {32'b0, left}) begin
                passed = passed - {32'b0, left};
                if (lvl) high_acc = high_acc + left;
                pred_res[pred_n] = '{box_level(tick), 52'd1, 1'b0};
                pred_n++;
                high_acc = '0;
                elapsed_acc = '0;
            end
            runs = passed / {32'b0, tick};
            passed = passed % {32'b0, tick};
            if (runs != '0) begin
                pred_res[pred_n] = '{lvl ? SMP_MAX : 8'd0, runs[ACC_W-1:0], 1'b0};
                pred_n++;
            end
            elapsed_acc = elapsed_acc + passed[31:0];
            if (lvl) high_acc = high_acc + passed[31:0];
            if (pred_n > 0) pred_res[pred_n-1].last = 1'b1;
        end
    endtask

    // register writes, accepted requests and returned samples, all seen at the edge
    always @(posedge i_clk) begin : scoreboard
        t_pcm got;
        t_pcm want;
        if (i_rst_n) begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_SAMPLE_RATE) sr_cfg = i_cfg_data[SR_W-1:0];
                else tick_cfg = i_cfg_data;
            end
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                predict_pcm(i_s_axis_tuser, i_s_axis_tdata[DUR_W-1:0], i_s_axis_tdata[DUR_W]);
                if (req_typed_n == UNTYPED) begin
                    for (int k = 0; k < pred_n; k++) pcm_expected_q.push_back(pred_res[k]);
                end else begin
                    for (int k = 0; k < req_typed_n; k++) pcm_expected_q.push_back(req_typed[k]);
                end
            end
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                got = '{o_m_axis_tdata[SMP_W-1:0], o_m_axis_tdata[SMP_W+ACC_W-1:SMP_W],
                        o_m_axis_tlast};
                if (pcm_expected_q.size() == 0) begin
                    $display("%0t: unexpected sample %0d x%0d last %0b", $time,
                             got.smp, got.reps, got.last);
                    mismatches++;
                end else begin
                    want = pcm_expected_q.pop_front();
                    if (got.smp != want.smp) begin
                        $display("%0t: sample expected %0d actual %0d", $time, want.smp, got.smp);
                        mismatches++;
                    end
                    if (got.reps != want.reps) begin
                        $display("%0t: repeat_count expected %0d actual %0d", $time,
                                 want.reps, got.reps);
                        mismatches++;
                    end
                    if (got.last != want.last) begin
                        $display("%0t: last expected %0b actual %0b", $time, want.last, got.last);
                        mismatches++;
                    end
                end
            end
        end
    end

    function automatic int draw_gap(bit rx_side);
        int calm;
        int gap;
        calm = rx_side ? rx_calm : tx_calm;
        if (calm > 0) begin
            calm--;
            gap = 0;
        end else if ($urandom_range(0, 11) == 0) begin
            calm = $urandom_range(8, 40);
            gap = 0;
        end else begin
            gap = $urandom_range(0, 16);
        end
        if (rx_side) rx_calm = calm;
        else tx_calm = calm;
        return gap;
    endfunction

    function automatic logic [DUR_W-1:0] draw_duration(logic [SR_W-1:0] sr,
                                                       logic [TR_W-1:0] tr);
        logic [63:0] span;
        logic [31:0] lim;
        span = (sr == '0) ? 64'd16 :
               ({32'b0, (tr == '0) ? 32'd1 : tr} * 64'd4) / {44'b0, sr} + 64'd2;
        lim = (span > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : span[31:0];
        case ($urandom_range(0, 9))
            0: return $urandom;
            1: return '0;
            2: return '1;
            3: return $urandom_range(0, 15);
            default: return $urandom_range(0, lim);
        endcase
    endfunction

    task automatic send_req(input logic rtype, input logic [DUR_W-1:0] dur, input logic lvl,
                            input int n_typed, input t_pcm r0, input t_pcm r1);
        int gap;
        gap = draw_gap(1'b0);
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser  <= rtype;
        i_s_axis_tdata  <= {{(IN_W-DUR_W-1){1'b0}}, lvl, dur};
        req_typed_n     <= n_typed;
        req_typed[0]    <= r0;
        req_typed[1]    <= r1;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
    endtask

    // drop valid, wait out every expected sample and the tail of a silent request
    task automatic settle();
        i_s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pcm_expected_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic idx, input logic [TR_W-1:0] value);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    initial begin : result_sink
        int gap;
        int taken;
        taken = 0;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            gap = draw_gap(1'b1);
            // one long hold-off so the block backs up into its input
            if (taken == HOLD_AT) gap = HOLD_CYC;
            if (gap > 0) begin
                i_m_axis_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_m_axis_tready <= 1'b1;
            @(posedge i_clk);
            while (!o_m_axis_tvalid) @(posedge i_clk);
            taken++;
        end
    end

    initial begin : stimulus
        logic [SR_W-1:0] sr;
        logic [TR_W-1:0] tr;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_tab[r]) begin
            if (dir_tab[r].kind == ROW_CFG) begin
                settle();
                cfg_write(dir_tab[r].idx, dir_tab[r].value);
            end else begin
                send_req(dir_tab[r].rtype, dir_tab[r].dur, dir_tab[r].lvl,
                         dir_tab[r].n_typed, dir_tab[r].r0, dir_tab[r].r1);
            end
        end

        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: begin sr = 20'd44100; tr = 32'd3500000; end
                1: begin sr = 20'd1; tr = 32'd1; end
                2: begin sr = '1; tr = '1; end
                3: begin sr = '1; tr = 32'd1; end
                4: begin sr = 20'd1; tr = '1; end
                5: begin
                    sr = SR_W'($urandom_range(1, 20'hF_FFFF));
                    tr = $urandom;
                    if (tr == '0) tr = 32'd1;
                end
                6: begin
                    sr = SR_W'($urandom_range(8000, 96000));
                    tr = $urandom_range(1000000, 8000000);
                end
                7: begin
                    sr = SR_W'($urandom_range(1, 64));
                    tr = $urandom_range(1, 1000);
                end
                default: begin sr = 20'd22050; tr = 32'd3500000; end
            endcase
            settle();
            cfg_write(CFG_SAMPLE_RATE, {12'b0, sr});
            cfg_write(CFG_TICK_RATE, tr);
            for (int i = 0; i < PHASE_REQS; i++) begin
                if ($urandom_range(0, 6) == 0) begin
                    send_req(REQ_FLUSH, $urandom, 1'($urandom_range(0, 1)), UNTYPED,
                             NO_RES, NO_RES);
                end else begin
                    send_req(REQ_PULSE, draw_duration(sr, tr), 1'($urandom_range(0, 1)),
                             UNTYPED, NO_RES, NO_RES);
                end
            end
        end

        settle();
        if (mismatches == 0 && pcm_expected_q.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin : watchdog
        #8_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/ptp_pkg.sv
rtl/pulse_to_pcm_box_resampler.sv
verif/tb_top.sv
